// ----- hdl/dehvd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dehvd_pkg
// Shared types, widths and helpers for the exception-header value decoder.
// ----------------------------------------------------------------------------
package dehvd_pkg;

    localparam int unsigned ValueWidth = 64;
    localparam int unsigned ByteWidth  = 8;
    localparam int unsigned EncWidth   = 8;
    localparam int unsigned CountWidth = 8;
    localparam int unsigned SizeWidth  = 4;
    localparam int unsigned CfgIdxWidth = 2;
    localparam int unsigned QueueDepth  = 2;

    // Configuration register indexes.
    localparam logic [CfgIdxWidth-1:0] CFG_LITTLE_ENDIAN = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_WIDE_WORDS    = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_DATA_BASE     = 2'd2;

    // Format nibble codes.
    localparam logic [3:0] FMT_WORD    = 4'h0;
    localparam logic [3:0] FMT_ULEB128 = 4'h1;
    localparam logic [3:0] FMT_UDATA2  = 4'h2;
    localparam logic [3:0] FMT_UDATA4  = 4'h3;
    localparam logic [3:0] FMT_UDATA8  = 4'h4;
    localparam logic [3:0] FMT_SLEB128 = 4'h9;
    localparam logic [3:0] FMT_SDATA2  = 4'ha;
    localparam logic [3:0] FMT_SDATA4  = 4'hb;
    localparam logic [3:0] FMT_SDATA8  = 4'hc;

    // Application (base) nibble codes.
    localparam logic [3:0] APP_PCREL   = 4'h1;
    localparam logic [3:0] APP_DATAREL = 4'h3;

    localparam logic [CountWidth-1:0] CountMax = '1;
    localparam logic [CountWidth-1:0] LebMaxChunks = 8'd10;

    // One finished datum handed from the front end to the back end.
    typedef struct packed {
        logic                  omit;
        logic [ValueWidth-1:0] acc;
        logic [CountWidth-1:0] count;
        logic [EncWidth-1:0]   enc;
        logic [ValueWidth-1:0] addr;
        logic [SizeWidth-1:0]  fsize;
        logic                  wide;
    } t_dehvd_item;

    function automatic logic fmt_known(input logic [3:0] fmt);
        logic r;
        case (fmt)
            FMT_WORD, FMT_ULEB128, FMT_UDATA2, FMT_UDATA4, FMT_UDATA8,
            FMT_SLEB128, FMT_SDATA2, FMT_SDATA4, FMT_SDATA8: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic fmt_is_leb(input logic [3:0] fmt);
        return (fmt == FMT_ULEB128) || (fmt == FMT_SLEB128);
    endfunction

    function automatic logic [SizeWidth-1:0] fixed_size(input logic [3:0] fmt,
                                                        input logic wide);
        logic [SizeWidth-1:0] r;
        case (fmt[2:0])
            FMT_UDATA2[2:0]: r = 4'd2;
            FMT_UDATA4[2:0]: r = 4'd4;
            FMT_UDATA8[2:0]: r = 4'd8;
            default:         r = wide ? 4'd8 : 4'd4;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/dehvd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dehvd_front
// Takes one stream byte per cycle unless the queue is full, classifies the
// encoding, assembles the raw datum and queues each done or omitted datum.
// ----------------------------------------------------------------------------
module dehvd_front import dehvd_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_queue_full,
    input  wire logic [ByteWidth-1:0]  i_data_byte,
    input  wire logic [EncWidth-1:0]   i_encoding,
    input  wire logic [ValueWidth-1:0] i_datum_address,
    input  wire logic                  i_little_endian,
    input  wire logic                  i_wide_words,
    output logic                       o_push,
    output t_dehvd_item                o_item
);

    logic                  r_busy;
    logic [EncWidth-1:0]   r_enc;
    logic [ValueWidth-1:0] r_addr;
    logic [ValueWidth-1:0] r_acc;
    logic [CountWidth-1:0] r_cnt;

    logic                  start;
    logic [EncWidth-1:0]   enc_eff;
    logic [ValueWidth-1:0] addr_eff;
    logic [ValueWidth-1:0] acc_eff;
    logic [CountWidth-1:0] cnt_eff;
    logic [3:0]            fmt;
    logic                  omit;
    logic                  is_leb;
    logic [SizeWidth-1:0]  fsize;
    logic [5:0]            leb_shift;
    logic [ValueWidth-1:0] n_acc;
    logic [CountWidth-1:0] n_cnt;
    logic [CountWidth:0]   cnt_plus;
    logic                  done;
    logic                  accept;

    always_comb begin
        start    = !r_busy;
        enc_eff  = start ? i_encoding : r_enc;
        addr_eff = start ? i_datum_address : r_addr;
        acc_eff  = start ? '0 : r_acc;
        cnt_eff  = start ? '0 : r_cnt;
        fmt      = enc_eff[3:0];
        omit     = start && !fmt_known(fmt);
        is_leb   = fmt_is_leb(fmt);
        fsize    = fixed_size(fmt, i_wide_words);
        leb_shift = 6'(cnt_eff[3:0]) * 6'd7;
        cnt_plus = {1'b0, cnt_eff} + 9'd1;
        n_acc    = acc_eff;
        if (is_leb) begin
            if (cnt_eff < LebMaxChunks) begin
                n_acc = acc_eff | ({57'd0, i_data_byte[6:0]} << leb_shift);
            end
            done = !i_data_byte[7];
        end else begin
            if (i_little_endian) begin
                // Bytes past the eighth fall off the top of the word.
                if (cnt_eff < 8'd8) begin
                    n_acc = acc_eff | ({56'd0, i_data_byte} << {cnt_eff[2:0], 3'b000});
                end
            end else begin
                n_acc = {acc_eff[ValueWidth-9:0], i_data_byte};
            end
            done = cnt_plus >= {5'd0, fsize};
        end
        n_cnt  = (cnt_eff < CountMax) ? cnt_plus[CountWidth-1:0] : cnt_eff;
        accept = i_in_valid && !i_queue_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (accept && !omit) begin
            r_busy <= !done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !omit) begin
            r_enc  <= enc_eff;
            r_addr <= addr_eff;
            r_acc  <= n_acc;
            r_cnt  <= n_cnt;
        end
    end

    always_comb begin
        o_push       = accept && (omit || done);
        o_item.omit  = omit;
        o_item.acc   = n_acc;
        o_item.count = n_cnt;
        o_item.enc   = enc_eff;
        o_item.addr  = addr_eff;
        o_item.fsize = fsize;
        o_item.wide  = i_wide_words;
    end

endmodule
`default_nettype wire

// ----- hdl/dehvd_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dehvd_queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module dehvd_queue import dehvd_pkg::*; #(
    parameter int unsigned DEPTH = QueueDepth
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_dehvd_item i_item,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_valid,
    output t_dehvd_item o_item
);

    localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntWidth = $clog2(DEPTH + 1);
    localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(DEPTH - 1);

    t_dehvd_item         r_mem [DEPTH];
    logic [PtrWidth-1:0] r_wr;
    logic [PtrWidth-1:0] r_rd;
    logic [CntWidth-1:0] r_cnt;
    logic                do_pop;

    assign o_full  = (r_cnt == CntWidth'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PtrLast) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PtrLast) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/dehvd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dehvd_back
// Sign-extends or masks a finished datum, adds its base, and holds the
// result word in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module dehvd_back import dehvd_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_q_valid,
    input  wire t_dehvd_item            i_item,
    input  wire logic [ValueWidth-1:0]  i_data_base,
    input  wire logic                   i_out_stall,
    output logic                        o_pop,
    output logic                        o_out_valid,
    output logic [ValueWidth-1:0]       o_value,
    output logic                        o_negative,
    output logic [CountWidth-1:0]       o_bytes_used
);

    logic                  r_valid;
    logic [ValueWidth-1:0] r_value;
    logic                  r_neg;
    logic [CountWidth-1:0] r_bytes;

    logic [3:0]            fmt;
    logic                  fmt_signed;
    logic [5:0]            sh;
    logic [ValueWidth-1:0] res;
    logic [ValueWidth-1:0] base;
    logic [ValueWidth-1:0] sum64;
    logic [31:0]           sum32;
    logic [ValueWidth-1:0] n_value;
    logic                  n_neg;

    always_comb begin
        fmt        = i_item.enc[3:0];
        fmt_signed = fmt[3];
        sh         = 6'(i_item.count[3:0]) * 6'd7;
        res        = i_item.acc;
        if (fmt_is_leb(fmt)) begin
            // Short SLEB128 values extend from their last chunk's top bit.
            if (fmt == FMT_SLEB128 && i_item.count <= 8'd9 && i_item.count != 8'd0) begin
                if (res[sh - 6'd1]) begin
                    res = res | ({ValueWidth{1'b1}} << sh);
                end
            end
        end else if (i_item.fsize == 4'd2) begin
            res = {{48{fmt_signed && res[15]}}, res[15:0]};
        end else if (i_item.fsize == 4'd4) begin
            res = {{32{fmt_signed && res[31]}}, res[31:0]};
        end

        case (i_item.enc[7:4])
            APP_PCREL:   base = i_item.addr;
            APP_DATAREL: base = i_data_base;
            default:     base = '0;
        endcase

        sum64 = res + base;
        sum32 = res[31:0] + base[31:0];
        if (i_item.omit) begin
            n_value = '0;
            n_neg   = 1'b0;
        end else if (i_item.wide) begin
            n_value = sum64;
            n_neg   = fmt_signed && sum64[ValueWidth-1];
        end else begin
            n_neg   = fmt_signed && sum32[31];
            n_value = {{32{n_neg}}, sum32};
        end

        o_pop = i_q_valid && (!r_valid || !i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_value <= n_value;
            r_neg   <= n_neg;
            r_bytes <= i_item.omit ? '0 : i_item.count;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_value      = r_value;
    assign o_negative   = r_neg;
    assign o_bytes_used = r_bytes;

endmodule
`default_nettype wire

// ----- hdl/dwarf_eh_value_decoder_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dwarf_eh_value_decoder_core
// Decodes exception-header encoded values (LEB128 and fixed-size formats,
// with pc-relative and data-relative bases) from a byte stream.
// Input channel: one stream byte per word, with the encoding byte and datum
// address sampled alongside the first byte of each datum. A word is taken
// when i_in_valid is high and o_in_stall is low. An omitted or unknown
// encoding seen at the start of a datum consumes nothing from the datum
// and yields a zero result with bytes_used of zero.
// Output channel: one result word per datum, taken when o_out_valid is
// high and i_out_stall is low; a stalled result holds its value.
// Throughput: one byte per cycle while o_in_stall is low, set by the front
// end's accumulator loop. A datum goes through the queue and output register.
// A two-entry queue parts the front end from the back end; o_in_stall rises
// only when the queue is full, i.e. when the receiver has stalled.
// Configuration: write index 0 little_endian, 1 wide_words, 2 data_base,
// only while the block is idle; o_cfg_ready is always high.
// Reset: synchronous, active low; clears control state and sets the defaults.
// ----------------------------------------------------------------------------
module dwarf_eh_value_decoder_core import dehvd_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [ByteWidth-1:0]   i_data_byte,
    input  wire logic [EncWidth-1:0]    i_encoding,
    input  wire logic [ValueWidth-1:0]  i_datum_address,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [ValueWidth-1:0]       o_value,
    output logic                        o_negative,
    output logic [CountWidth-1:0]       o_bytes_used,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CfgIdxWidth-1:0] i_cfg_index,
    input  wire logic [ValueWidth-1:0]  i_cfg_data
);

    logic                  r_little_endian;
    logic                  r_wide_words;
    logic [ValueWidth-1:0] r_data_base;

    logic        queue_full;
    logic        push;
    logic        pop;
    logic        q_valid;
    t_dehvd_item front_item;
    t_dehvd_item q_item;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = queue_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_little_endian <= 1'b1;
            r_wide_words    <= 1'b1;
            r_data_base     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LITTLE_ENDIAN: r_little_endian <= i_cfg_data[0];
                CFG_WIDE_WORDS:    r_wide_words    <= i_cfg_data[0];
                CFG_DATA_BASE:     r_data_base     <= i_cfg_data;
                default:           ;
            endcase
        end
    end

    dehvd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_queue_full    (queue_full),
        .i_data_byte     (i_data_byte),
        .i_encoding      (i_encoding),
        .i_datum_address (i_datum_address),
        .i_little_endian (r_little_endian),
        .i_wide_words    (r_wide_words),
        .o_push          (push),
        .o_item          (front_item)
    );

    dehvd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    dehvd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_item       (q_item),
        .i_data_base  (r_data_base),
        .i_out_stall  (i_out_stall),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .o_value      (o_value),
        .o_negative   (o_negative),
        .o_bytes_used (o_bytes_used)
    );

endmodule
`default_nettype wire

// ----- hdl/dehvd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dehvd_checker
// Port-level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
module dehvd_checker import dehvd_pkg::*; (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_stall,
    input wire logic [ValueWidth-1:0] o_value,
    input wire logic                  o_negative,
    input wire logic [CountWidth-1:0] o_bytes_used
);

    // A stalled result word stays offered.
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word withdrawn while stalled");

    // A stalled result word keeps its payload.
    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_value) && $stable(o_negative) && $stable(o_bytes_used))
        else $error("result payload changed while stalled");

    // An omitted datum always reports a clean zero.
    a_omit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bytes_used == 8'd0 |-> o_value == '0 && !o_negative)
        else $error("omitted datum with nonzero value");

    // Negative results are always sign-extended through bit 63.
    a_neg_signext: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_negative |-> o_value[ValueWidth-1])
        else $error("negative result not sign-extended");

endmodule

bind dwarf_eh_value_decoder_core dehvd_checker u_dehvd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_value      (o_value),
    .o_negative   (o_negative),
    .o_bytes_used (o_bytes_used)
);
`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for dwarf_eh_value_decoder_core. A scoreboard keeps its
// own copy of the decoder state and registers, predicts the result of every
// accepted byte word and checks the results in order. Directed data cover the
// format and base extremes, long LEB128 runs, omitted formats and a register
// change inside a datum; random phases follow under several register settings
// with random gaps on both channels, two of them opening with saturating runs.
// ----------------------------------------------------------------------------
module tb;
    import dehvd_pkg::*;

    localparam int unsigned StallLimit = 3000;
    localparam logic [CfgIdxWidth-1:0] CfgSpare = 2'd3;

    typedef struct packed {
        logic [ValueWidth-1:0] value;
        logic                  negative;
        logic [CountWidth-1:0] bytes_used;
    } t_decoded;

    class datum_scoreboard;
        bit                    little_endian;
        bit                    wide_words;
        logic [ValueWidth-1:0] data_base;
        logic [ValueWidth-1:0] acc;
        int unsigned           count;
        bit                    busy;
        logic [EncWidth-1:0]   enc_held;
        logic [ValueWidth-1:0] addr_held;
        t_decoded              expected[$];
        int unsigned           mismatches;

        function new();
            little_endian = 1'b1;
            wide_words    = 1'b1;
            data_base     = '0;
            acc           = '0;
            count         = 0;
            busy          = 1'b0;
            enc_held      = '0;
            addr_held     = '0;
            mismatches    = 0;
        endfunction

        function void apply_reg(logic [CfgIdxWidth-1:0] idx, logic [ValueWidth-1:0] data);
            case (idx)
                CFG_LITTLE_ENDIAN: little_endian = data[0];
                CFG_WIDE_WORDS:    wide_words = data[0];
                CFG_DATA_BASE:     data_base = data;
                default: ;
            endcase
        endfunction

        function bit format_known(logic [3:0] fmt);
            case (fmt)
                FMT_WORD, FMT_ULEB128, FMT_UDATA2, FMT_UDATA4, FMT_UDATA8,
                FMT_SLEB128, FMT_SDATA2, FMT_SDATA4, FMT_SDATA8: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        // Word-size formats follow wide_words as it stands at this byte.
        function int unsigned fixed_bytes(logic [3:0] fmt);
            case (fmt[2:0])
                FMT_UDATA2[2:0]: return 2;
                FMT_UDATA4[2:0]: return 4;
                FMT_UDATA8[2:0]: return 8;
                default:         return wide_words ? 8 : 4;
            endcase
        endfunction

        function void note_input(logic [ByteWidth-1:0] b, logic [EncWidth-1:0] enc,
                                 logic [ValueWidth-1:0] addr);
            logic [3:0]            fmt;
            logic [3:0]            app;
            bit                    is_leb;
            bit                    fmt_signed;
            bit                    done;
            bit                    neg;
            int unsigned           fsize;
            int unsigned           prev_count;
            int unsigned           sh;
            logic [ValueWidth-1:0] res;
            logic [ValueWidth-1:0] mask;
            logic [ValueWidth-1:0] base;
            logic [31:0]           r32;
            t_decoded              r;

            if (!busy) begin
                // An omitted or unknown format yields an empty result at once.
                if (!format_known(enc[3:0])) begin
                    r = '0;
                    expected.push_back(r);
                    return;
                end
                enc_held  = enc;
                addr_held = addr;
                acc       = '0;
                count     = 0;
                busy      = 1'b1;
            end

            fmt        = enc_held[3:0];
            is_leb     = (fmt == FMT_ULEB128) || (fmt == FMT_SLEB128);
            fmt_signed = fmt[3];
            prev_count = count;
            fsize      = 0;

            if (is_leb) begin
                if (prev_count < 10) acc |= 64'(b[6:0]) << (7 * prev_count);
                done = !b[7];
            end else begin
                fsize = fixed_bytes(fmt);
                if (little_endian) begin
                    if (prev_count < 8) acc |= 64'(b) << (8 * prev_count);
                end else begin
                    acc = {acc[55:0], b};
                end
                done = (prev_count + 1 >= fsize);
            end
            if (count < 255) count++;
            if (!done) return;

            res = acc;
            if (is_leb) begin
                // Ten or more bytes fill the word, so no sign extension then.
                if (fmt == FMT_SLEB128 && count <= 9) begin
                    sh = 7 * count;
                    if (res[sh-1]) res |= ~64'd0 << sh;
                end
            end else if (fsize < 8) begin
                mask = (64'd1 << (8 * fsize)) - 64'd1;
                res &= mask;
                if (fmt_signed && res[8*fsize-1]) res |= ~mask;
            end

            app  = enc_held[7:4];
            base = '0;
            if (app == APP_PCREL) base = addr_held;
            else if (app == APP_DATAREL) base = data_base;

            neg = 1'b0;
            if (!wide_words) begin
                r32 = res[31:0] + base[31:0];
                if (fmt_signed) begin
                    neg = r32[31];
                    res = neg ? {32'hffff_ffff, r32} : {32'h0, r32};
                end else begin
                    res = {32'h0, r32};
                end
            end else begin
                res = res + base;
                if (fmt_signed) neg = res[63];
            end

            r.value      = res;
            r.negative   = neg;
            r.bytes_used = 8'(count);
            expected.push_back(r);
            busy = 1'b0;
        endfunction

        function void check_result(logic [ValueWidth-1:0] value, logic negative,
                                   logic [CountWidth-1:0] bytes_used);
            t_decoded want;

            if (expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value %h negative %b bytes_used %0d",
                             value, negative, bytes_used);
                return;
            end
            want = expected.pop_front();
            if (value !== want.value || negative !== want.negative ||
                bytes_used !== want.bytes_used) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: value %h/%h negative %b/%b bytes_used %0d/%0d (exp/act)",
                             want.value, value, want.negative, negative,
                             want.bytes_used, bytes_used);
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n         = 1'b0;
    logic                   i_in_valid      = 1'b0;
    logic                   o_in_stall;
    logic [ByteWidth-1:0]   i_data_byte     = '0;
    logic [EncWidth-1:0]    i_encoding      = '0;
    logic [ValueWidth-1:0]  i_datum_address = '0;
    logic                   o_out_valid;
    logic                   i_out_stall     = 1'b0;
    logic [ValueWidth-1:0]  o_value;
    logic                   o_negative;
    logic [CountWidth-1:0]  o_bytes_used;
    logic                   i_cfg_valid     = 1'b0;
    logic                   o_cfg_ready;
    logic [CfgIdxWidth-1:0] i_cfg_index     = '0;
    logic [ValueWidth-1:0]  i_cfg_data      = '0;

    datum_scoreboard sb;
    bit              calm = 1'b0;
    int unsigned     words_sent = 0;
    int unsigned     idle_cycles = 0;

    dwarf_eh_value_decoder_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_encoding      (i_encoding),
        .i_datum_address (i_datum_address),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_value         (o_value),
        .o_negative      (o_negative),
        .o_bytes_used    (o_bytes_used),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            sb.note_input(i_data_byte, i_encoding, i_datum_address);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_value, o_negative, o_bytes_used);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready)
            sb.apply_reg(i_cfg_index, i_cfg_data);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < StallLimit) @(posedge i_clk);
        $display("dwarf_eh_value_decoder_core regression: fail");
        $finish;
    end

    // Receiver: holds stall for random stretches, mostly short.
    initial begin
        int unsigned hold;
        int unsigned r;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold != 0) begin
                hold--;
            end else if (!calm) begin
                r = $urandom_range(0, 99);
                if (r < 60) hold = 0;
                else if (r < 93) hold = $urandom_range(1, 3);
                else hold = $urandom_range(8, 30);
            end
            i_out_stall <= (hold != 0);
        end
    end

    function automatic logic [ValueWidth-1:0] rand_word();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 64'h8000_0000_0000_0000;
            3:       return 64'h0000_0000_ffff_ffff;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic feed_byte(input logic [ByteWidth-1:0] b, input logic [EncWidth-1:0] enc,
                             input logic [ValueWidth-1:0] addr);
        int unsigned gap;
        i_in_valid      <= 1'b1;
        i_data_byte     <= b;
        i_encoding      <= enc;
        i_datum_address <= addr;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Encoding and address matter only on the first byte; later words carry noise there.
    task automatic send_datum(input logic [EncWidth-1:0] enc, input logic [ValueWidth-1:0] addr,
                              input logic [ByteWidth-1:0] bytes[$]);
        int unsigned i;
        for (i = 0; i < bytes.size(); i++) begin
            if (i == 0) feed_byte(bytes[i], enc, addr);
            else feed_byte(bytes[i], 8'($urandom), rand_word());
        end
    endtask

    task automatic program_reg(input logic [CfgIdxWidth-1:0] idx,
                               input logic [ValueWidth-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits for every predicted result plus the pipeline depth before a register write.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_datum(input bit long_leb);
        logic [ByteWidth-1:0] bytes[$];
        logic [EncWidth-1:0]  enc;
        logic [3:0]           fmt;
        logic [ByteWidth-1:0] b;
        int unsigned          r;
        int unsigned          len;
        int unsigned          i;
        int unsigned          pattern;

        r = $urandom_range(0, 99);
        if (long_leb) begin
            enc = {4'($urandom_range(0, 15)),
                   ($urandom_range(0, 1) != 0) ? FMT_SLEB128 : FMT_ULEB128};
        end else if (r < 8) begin
            if ($urandom_range(0, 3) == 0) enc = 8'hff;
            else if ($urandom_range(0, 1) != 0)
                enc = {4'($urandom_range(0, 15)), 4'($urandom_range(5, 8))};
            else
                enc = {4'($urandom_range(0, 15)), 4'($urandom_range(13, 15))};
        end else if (r < 13) begin
            enc = 8'($urandom_range(0, 255));
        end else begin
            case ($urandom_range(0, 8))
                0:       fmt = FMT_WORD;
                1:       fmt = FMT_ULEB128;
                2:       fmt = FMT_UDATA2;
                3:       fmt = FMT_UDATA4;
                4:       fmt = FMT_UDATA8;
                5:       fmt = FMT_SLEB128;
                6:       fmt = FMT_SDATA2;
                7:       fmt = FMT_SDATA4;
                default: fmt = FMT_SDATA8;
            endcase
            r = $urandom_range(0, 99);
            if (r < 35) enc = {4'h0, fmt};
            else if (r < 60) enc = {APP_PCREL, fmt};
            else if (r < 85) enc = {APP_DATAREL, fmt};
            else enc = {4'($urandom_range(0, 15)), fmt};
        end

        fmt = enc[3:0];
        if (!sb.format_known(fmt)) begin
            len = 1;
        end else if (fmt == FMT_ULEB128 || fmt == FMT_SLEB128) begin
            r = $urandom_range(0, 99);
            if (long_leb) len = $urandom_range(256, 262);
            else if (r < 35) len = 1;
            else if (r < 70) len = $urandom_range(2, 4);
            else if (r < 90) len = $urandom_range(5, 10);
            else len = $urandom_range(11, 14);
        end else begin
            len = sb.fixed_bytes(fmt);
        end

        pattern = $urandom_range(0, 9);
        for (i = 0; i < len; i++) begin
            case (pattern)
                0:       b = 8'h00;
                1:       b = 8'hff;
                2:       b = (i == len - 1) ? 8'h80 : 8'h00;
                default: b = 8'($urandom);
            endcase
            if (fmt == FMT_ULEB128 || fmt == FMT_SLEB128) b[7] = (i < len - 1);
            bytes.push_back(b);
        end
        send_datum(enc, rand_word(), bytes);
    endtask

    initial begin
        int unsigned phase;
        int unsigned goal;

        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults: little endian, 64-bit words, zero data base.
        send_datum({4'h0, FMT_ULEB128}, rand_word(), '{8'h00});
        send_datum({4'h0, FMT_ULEB128}, rand_word(), '{8'hff, 8'h7f});
        send_datum({4'h0, FMT_SLEB128}, rand_word(), '{8'h7f});
        send_datum({4'h0, FMT_SLEB128}, rand_word(), '{8'h80, 8'h01});
        send_datum({4'h0, FMT_SDATA2}, rand_word(), '{8'h00, 8'h80});
        send_datum({4'h0, FMT_UDATA4}, rand_word(), '{8'hff, 8'hff, 8'hff, 8'hff});
        send_datum({4'h0, FMT_SDATA8}, rand_word(),
                   '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
        send_datum({APP_PCREL, FMT_UDATA8}, '1,
                   '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        send_datum(8'hff, rand_word(), '{8'h5a});
        send_datum({4'h8, 4'h5}, rand_word(), '{8'ha5});
        send_datum({4'h0, FMT_WORD}, rand_word(),
                   '{8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hab, 8'hcd, 8'hef});
        // Long LEB128 runs: chunks past bit 64 drop, ten-byte SLEB is not extended.
        send_datum({4'h0, FMT_ULEB128}, rand_word(),
                   '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                     8'h01});
        send_datum({4'h0, FMT_SLEB128}, rand_word(),
                   '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h7f});

        settle();
        program_reg(CFG_LITTLE_ENDIAN, 64'd0);
        program_reg(CFG_WIDE_WORDS, 64'd0);
        program_reg(CFG_DATA_BASE, '1);
        program_reg(CfgSpare, rand_word());
        send_datum({APP_DATAREL, FMT_SDATA4}, rand_word(), '{8'h7f, 8'hff, 8'hff, 8'hff});
        send_datum({4'h0, FMT_WORD}, rand_word(), '{8'h80, 8'h00, 8'h00, 8'h01});
        send_datum({APP_PCREL, FMT_SDATA2}, 64'h0000_0000_ffff_fffe, '{8'h00, 8'h01});
        send_datum({APP_DATAREL, FMT_UDATA2}, rand_word(), '{8'h00, 8'h02});

        // Registers change while a word-size datum is half done.
        settle();
        program_reg(CFG_WIDE_WORDS, 64'd1);
        program_reg(CFG_LITTLE_ENDIAN, 64'd1);
        feed_byte(8'h11, {4'h0, FMT_WORD}, rand_word());
        feed_byte(8'h22, 8'($urandom), rand_word());
        feed_byte(8'h33, 8'($urandom), rand_word());
        settle();
        program_reg(CFG_WIDE_WORDS, 64'd0);
        program_reg(CFG_LITTLE_ENDIAN, 64'd0);
        feed_byte(8'h44, 8'($urandom), rand_word());

        settle();
        program_reg(CFG_DATA_BASE, 64'h8000_0000_0000_0000);
        program_reg(CFG_WIDE_WORDS, 64'd1);
        program_reg(CFG_LITTLE_ENDIAN, 64'd1);
        send_datum({APP_DATAREL, FMT_SDATA8}, rand_word(),
                   '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});

        for (phase = 0; phase < 8; phase++) begin
            settle();
            calm = (phase == 3) || (phase == 6);
            case (phase)
                0: begin
                    program_reg(CFG_LITTLE_ENDIAN, 64'd1);
                    program_reg(CFG_WIDE_WORDS, 64'd1);
                    program_reg(CFG_DATA_BASE, '0);
                end
                1: begin
                    program_reg(CFG_LITTLE_ENDIAN, 64'd0);
                    program_reg(CFG_WIDE_WORDS, 64'd0);
                    program_reg(CFG_DATA_BASE, '1);
                end
                default: begin
                    program_reg(CFG_LITTLE_ENDIAN, 64'($urandom_range(0, 1)));
                    program_reg(CFG_WIDE_WORDS, 64'($urandom_range(0, 1)));
                    program_reg(CFG_DATA_BASE, rand_word());
                end
            endcase
            goal = words_sent + 190;
            // Two phases open with a LEB128 run long enough to saturate the count.
            if (phase == 2 || phase == 5) random_datum(1'b1);
            while (words_sent < goal) random_datum(1'b0);
        end

        calm = 1'b0;
        settle();
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected.size() == 0) begin
            $display("dwarf_eh_value_decoder_core regression: pass");
        end else begin
            $display("dwarf_eh_value_decoder_core regression: fail");
        end
        $finish;
    end

endmodule
